### hdl/rmq_pkg.sv
// Shared types and fixed widths for the rotation matrix to quaternion core.
// No dependencies; used by the core and its port checker.
package rmq_pkg;

	localparam int ELEM_W  = 16;
	localparam int DIFF_W  = 17;
	localparam int QUAT_W  = 16;
	localparam int IN_W    = 9 * ELEM_W;
	localparam int OUT_W   = 4 * QUAT_W;
	localparam int USER_W  = 3;

	typedef enum logic [1:0] {
		CASE_TRACE = 2'd0,
		CASE_X     = 2'd1,
		CASE_Y     = 2'd2,
		CASE_Z     = 2'd3
	} case_t;

endpackage

### hdl/rmq_sqrt_cell.sv
// One restoring square-root step: consumes two radicand bits, emits one root bit.
// Standalone; carries an opaque payload alongside the partial root.
module rmq_sqrt_cell #(
	parameter int NB = 17,
	parameter int RW = 34,
	parameter int PW = 54
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [RW-1:0] in_rad,
	input  logic [NB+1:0] in_rem,
	input  logic [NB-1:0] in_root,
	input  logic [PW-1:0] in_pay,
	output logic          out_v,
	output logic [RW-1:0] out_rad,
	output logic [NB+1:0] out_rem,
	output logic [NB-1:0] out_root,
	output logic [PW-1:0] out_pay
);

	logic [NB+1:0] rem_sh;
	logic [NB+1:0] trial;
	logic          ge;

	always_comb begin
		rem_sh = {in_rem[NB-1:0], in_rad[RW-1 -: 2]};
		trial  = {in_root, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rad  <= {in_rad[RW-3:0], 2'b00};
			out_rem  <= ge ? (rem_sh - trial) : rem_sh;
			out_root <= {in_root[NB-2:0], ge};
			out_pay  <= in_pay;
		end
	end

endmodule

### hdl/rmq_div_cell.sv
// One restoring division step for several lanes sharing a divisor.
// Standalone; dividend register shifts out numerator bits and shifts in quotient bits.
module rmq_div_cell #(
	parameter int NB    = 17,
	parameter int NW    = 31,
	parameter int PW    = 22,
	parameter int LANES = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_v,
	input  logic [NB:0]                in_den,
	input  logic [LANES-1:0][NW-1:0]   in_num,
	input  logic [LANES-1:0][NB:0]     in_rem,
	input  logic [PW-1:0]              in_pay,
	output logic                       out_v,
	output logic [NB:0]                out_den,
	output logic [LANES-1:0][NW-1:0]   out_num,
	output logic [LANES-1:0][NB:0]     out_rem,
	output logic [PW-1:0]              out_pay
);

	logic [LANES-1:0][NB+1:0] rem_sh;
	logic [LANES-1:0][NB+1:0] rem_sub;
	logic [LANES-1:0]         ge;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_sh[l]  = {in_rem[l], in_num[l][NW-1]};
			ge[l]      = rem_sh[l] >= {1'b0, in_den};
			rem_sub[l] = rem_sh[l] - {1'b0, in_den};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_den <= in_den;
			out_pay <= in_pay;
			for (int l = 0; l < LANES; l++) begin
				out_num[l] <= {in_num[l][NW-2:0], ge[l]};
				out_rem[l] <= ge[l] ? rem_sub[l][NB:0] : rem_sh[l][NB:0];
			end
		end
	end

endmodule

### hdl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to quaternion converter (Shepperd's method), fixed point.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
//
// Usage:
//   Slave channel: one 3x3 matrix per transaction, nine signed elements with
//   FRAC_BITS fraction bits. Master channel: qx, qy, qz, qw in tdata and the
//   chosen branch plus a degenerate flag in tuser.
//   Pipeline: a front register, NB square-root cells, NW divider cells
//   and the output register lie between accept and the master side,
//   where NB = root bits (one square-root cell each) and NW = 17 + FRAC_BITS
//   quotient bits (one divider cell each). FRAC_BITS = 14 gives NB = 16, NW = 31.
//   Throughput: one transaction per cycle while results are taken; every cell
//   hands its partial result to the next cell on each enabled clock.
//   Stall: when a result sits on the master side without tready, the whole
//   cell chain holds and s_tready drops; bubbles in the chain keep moving
//   only while the output register is empty or being taken.
//   Reset: clears every valid bit; payload registers are not reset.
module rotation_matrix_to_quaternion_core #(
	parameter int FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
	input  logic [rmq_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// qx, qy, qz, qw (16 bits each, lowest first)
	output logic [rmq_pkg::OUT_W-1:0]  m_tdata,
	// case_taken [1:0], degenerate [2]
	output logic [rmq_pkg::USER_W-1:0] m_tuser
);

	import rmq_pkg::*;

	// Root argument fits UA bits when positive; SA covers its signed range.
	localparam int UA  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int SA  = UA + 1;
	localparam int RW  = UA + FRAC_BITS;
	localparam int RW2 = RW + (RW % 2);
	localparam int NB  = RW2 / 2;
	localparam int NW  = DIFF_W + FRAC_BITS;
	localparam int PWS = 3 + 3 * DIFF_W;
	localparam int PWD = 3 + NB + 3;

	logic en;

	// ---------------------------------------------------------------
	// Front stage: trace, branch choice, root argument, skew terms
	// ---------------------------------------------------------------
	logic signed [SA-1:0]     e [9];
	logic signed [DIFF_W-1:0] m [9];
	logic signed [SA-1:0]     trace;
	logic signed [SA-1:0]     arg;
	logic signed [SA-1:0]     one_c;
	case_t                    which;
	logic signed [DIFF_W-1:0] d0, d1, d2;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			e[i] = SA'($signed(s_tdata[ELEM_W*i +: ELEM_W]));
			m[i] = DIFF_W'($signed(s_tdata[ELEM_W*i +: ELEM_W]));
		end
		one_c = SA'(1) <<< FRAC_BITS;
		trace = e[0] + e[4] + e[8];
		if (trace > 0) begin
			which = CASE_TRACE;
			arg   = trace + one_c;
			d0    = m[7] - m[5];
			d1    = m[2] - m[6];
			d2    = m[3] - m[1];
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			which = CASE_X;
			arg   = one_c + e[0] - e[4] - e[8];
			d0    = m[1] + m[3];
			d1    = m[2] + m[6];
			d2    = m[7] - m[5];
		end else if (e[4] > e[8]) begin
			which = CASE_Y;
			arg   = one_c + e[4] - e[0] - e[8];
			d0    = m[1] + m[3];
			d1    = m[5] + m[7];
			d2    = m[2] - m[6];
		end else begin
			which = CASE_Z;
			arg   = one_c + e[8] - e[0] - e[4];
			d0    = m[2] + m[6];
			d1    = m[5] + m[7];
			d2    = m[3] - m[1];
		end
	end

	logic                     v_s1;
	logic [UA-1:0]            arg_s1;
	logic [PWS-1:0]           pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	// Non-positive argument: flag degenerate now, feed a zero radicand.
	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1 <= (arg > 0) ? arg[UA-1:0] : '0;
			pay_s1 <= {which, (arg <= 0), d2, d1, d0};
		end
	end

	// ---------------------------------------------------------------
	// Square-root chain: one cell per root bit
	// ---------------------------------------------------------------
	logic            sq_v    [NB+1];
	logic [RW2-1:0]  sq_rad  [NB+1];
	logic [NB+1:0]   sq_rem  [NB+1];
	logic [NB-1:0]   sq_root [NB+1];
	logic [PWS-1:0]  sq_pay  [NB+1];

	always_comb begin
		sq_v[0]    = v_s1;
		sq_rad[0]  = RW2'(arg_s1) << FRAC_BITS;
		sq_rem[0]  = '0;
		sq_root[0] = '0;
		sq_pay[0]  = pay_s1;
	end

	for (genvar g = 0; g < NB; g++) begin : g_sqrt
		rmq_sqrt_cell #(.NB(NB), .RW(RW2), .PW(PWS)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_v    (sq_v[g]),
			.in_rad  (sq_rad[g]),
			.in_rem  (sq_rem[g]),
			.in_root (sq_root[g]),
			.in_pay  (sq_pay[g]),
			.out_v   (sq_v[g+1]),
			.out_rad (sq_rad[g+1]),
			.out_rem (sq_rem[g+1]),
			.out_root(sq_root[g+1]),
			.out_pay (sq_pay[g+1])
		);
	end

	// ---------------------------------------------------------------
	// Divider chain: three lanes share the divisor 2r
	// ---------------------------------------------------------------
	logic                    dv_v   [NW+1];
	logic [NB:0]             dv_den [NW+1];
	logic [2:0][NW-1:0]      dv_num [NW+1];
	logic [2:0][NB:0]        dv_rem [NW+1];
	logic [PWD-1:0]          dv_pay [NW+1];

	logic [NB-1:0]             root_f;
	logic signed [DIFF_W-1:0]  dl [3];
	logic [DIFF_W-1:0]         mag [3];
	logic [2:0]                sgn;

	always_comb begin
		root_f = sq_root[NB];
		for (int l = 0; l < 3; l++) begin
			dl[l]  = $signed(sq_pay[NB][DIFF_W*l +: DIFF_W]);
			sgn[l] = dl[l][DIFF_W-1];
			mag[l] = sgn[l] ? DIFF_W'(-dl[l]) : DIFF_W'(dl[l]);
			dv_num[0][l] = {mag[l], {FRAC_BITS{1'b0}}};
		end
		dv_v[0]   = sq_v[NB];
		dv_den[0] = {root_f, 1'b0};
		dv_rem[0] = '0;
		dv_pay[0] = {sq_pay[NB][PWS-1 -: 2],
		             sq_pay[NB][PWS-3] | (root_f == '0),
		             root_f >> 1, sgn};
	end

	for (genvar g = 0; g < NW; g++) begin : g_div
		rmq_div_cell #(.NB(NB), .NW(NW), .PW(PWD), .LANES(3)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (dv_v[g]),
			.in_den (dv_den[g]),
			.in_num (dv_num[g]),
			.in_rem (dv_rem[g]),
			.in_pay (dv_pay[g]),
			.out_v  (dv_v[g+1]),
			.out_den(dv_den[g+1]),
			.out_num(dv_num[g+1]),
			.out_rem(dv_rem[g+1]),
			.out_pay(dv_pay[g+1])
		);
	end

	// ---------------------------------------------------------------
	// Output stage: sign, saturate, place lanes by branch
	// ---------------------------------------------------------------
	function automatic logic [QUAT_W-1:0] sat_q(input logic neg, input logic [NW-1:0] q);
		logic [QUAT_W-1:0] r;
		if (!neg) begin
			r = (q > NW'(32767)) ? 16'h7FFF : q[QUAT_W-1:0];
		end else begin
			r = (q > NW'(32768)) ? 16'h8000 : QUAT_W'(-q);
		end
		return r;
	endfunction

	logic [PWD-1:0]     pay_f;
	case_t              which_f;
	logic               degen_f;
	logic [NB-1:0]      half_f;
	logic [63:0]        half_w;
	logic [QUAT_W-1:0]  lane_q [3];
	logic [QUAT_W-1:0]  half_q;
	logic [QUAT_W-1:0]  qx, qy, qz, qw;

	always_comb begin
		pay_f   = dv_pay[NW];
		which_f = case_t'(pay_f[PWD-1 -: 2]);
		degen_f = pay_f[PWD-3];
		half_f  = pay_f[NB+2:3];
		// Widen before saturating so any root width compares cleanly.
		half_w  = 64'(half_f);
		half_q  = (half_w > 64'd32767) ? 16'h7FFF : half_w[QUAT_W-1:0];
		for (int l = 0; l < 3; l++) begin
			lane_q[l] = sat_q(pay_f[l], dv_num[NW][l]);
		end
		unique case (which_f)
			CASE_TRACE: begin
				qx = lane_q[0]; qy = lane_q[1]; qz = lane_q[2]; qw = half_q;
			end
			CASE_X: begin
				qx = half_q; qy = lane_q[0]; qz = lane_q[1]; qw = lane_q[2];
			end
			CASE_Y: begin
				qx = lane_q[0]; qy = half_q; qz = lane_q[1]; qw = lane_q[2];
			end
			default: begin
				qx = lane_q[0]; qy = lane_q[1]; qz = half_q; qw = lane_q[2];
			end
		endcase
		if (degen_f) begin
			qx = '0; qy = '0; qz = '0; qw = '0;
		end
	end

	logic                v_out_q;
	logic [OUT_W-1:0]    data_out_q;
	logic [USER_W-1:0]   user_out_q;

	// Advance the whole chain unless a result waits untaken.
	assign en       = !v_out_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= dv_v[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_out_q <= {qw, qz, qy, qx};
			user_out_q <= {degen_f, which_f};
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = data_out_q;
	assign m_tuser  = user_out_q;

endmodule

### hdl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion core.
// Depends on rmq_pkg; bound to the core below.
module rmq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [rmq_pkg::OUT_W-1:0]  m_tdata,
	input logic [rmq_pkg::USER_W-1:0] m_tuser
);

	import rmq_pkg::*;

	// Hold a stalled result unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Degenerate results carry all-zero components.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == '0)
		else $error("degenerate result with nonzero components");

	// Accept input whenever the output side can drain.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled while output free");

	// Drop ready only while a result waits.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (.*);

### verif/testbench.sv
// Self-checking bench for rotation_matrix_to_quaternion_core: random and directed matrices,
// a queue-fed driver, a checking monitor and a stall watchdog. Depends on rmq_pkg.
`timescale 1ns / 100ps
module testbench;
	import rmq_pkg::*;

	localparam int FRAC = 14;
	localparam int LATENCY = 48;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] qw, qz, qy, qx;
		case_t       branch;
		logic        degen;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;

	rotation_matrix_to_quaternion_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	logic [IN_W-1:0] pending_mats[$];
	quat_t expected_quats[$];
	int errors = 0;
	bit hold_receiver = 0;
	int idle_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned a);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > a) bitv >>= 2;
		while (bitv != 0) begin
			if (a >= r + bitv) begin
				a -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// Shepperd conversion at the block's fixed-point widths.
	function automatic quat_t convert_matrix(logic [IN_W-1:0] mat);
		longint m[9];
		longint trace, arg, r, den, qx, qy, qz, qw;
		quat_t q;
		for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[i*16 +: 16]));
		qx = 0; qy = 0; qz = 0; qw = 0;
		q.degen = 1'b0;
		trace = m[0] + m[4] + m[8];
		if (trace > 0) begin
			q.branch = CASE_TRACE;
			arg = trace + (64'sd1 <<< FRAC);
		end else if (m[0] > m[4] && m[0] > m[8]) begin
			q.branch = CASE_X;
			arg = (64'sd1 <<< FRAC) + m[0] - m[4] - m[8];
		end else if (m[4] > m[8]) begin
			q.branch = CASE_Y;
			arg = (64'sd1 <<< FRAC) + m[4] - m[0] - m[8];
		end else begin
			q.branch = CASE_Z;
			arg = (64'sd1 <<< FRAC) + m[8] - m[0] - m[4];
		end
		if (arg <= 0) begin
			q.degen = 1'b1;
		end else begin
			r = longint'(root_floor(longint'(arg) << FRAC));
			den = 2 * r;
			if (r == 0) begin
				q.degen = 1'b1;
			end else begin
				case (q.branch)
					CASE_TRACE: begin
						qx = ((m[7] - m[5]) * (64'sd1 <<< FRAC)) / den;
						qy = ((m[2] - m[6]) * (64'sd1 <<< FRAC)) / den;
						qz = ((m[3] - m[1]) * (64'sd1 <<< FRAC)) / den;
						qw = r >>> 1;
					end
					CASE_X: begin
						qx = r >>> 1;
						qy = ((m[1] + m[3]) * (64'sd1 <<< FRAC)) / den;
						qz = ((m[2] + m[6]) * (64'sd1 <<< FRAC)) / den;
						qw = ((m[7] - m[5]) * (64'sd1 <<< FRAC)) / den;
					end
					CASE_Y: begin
						qx = ((m[1] + m[3]) * (64'sd1 <<< FRAC)) / den;
						qy = r >>> 1;
						qz = ((m[5] + m[7]) * (64'sd1 <<< FRAC)) / den;
						qw = ((m[2] - m[6]) * (64'sd1 <<< FRAC)) / den;
					end
					default: begin
						qx = ((m[2] + m[6]) * (64'sd1 <<< FRAC)) / den;
						qy = ((m[5] + m[7]) * (64'sd1 <<< FRAC)) / den;
						qz = r >>> 1;
						qw = ((m[3] - m[1]) * (64'sd1 <<< FRAC)) / den;
					end
				endcase
			end
		end
		if (q.degen) begin
			qx = 0; qy = 0; qz = 0; qw = 0;
		end
		q.qx = clamp16(qx);
		q.qy = clamp16(qy);
		q.qz = clamp16(qz);
		q.qw = clamp16(qw);
		return q;
	endfunction

	function automatic logic [IN_W-1:0] pack_mat(int e0, int e1, int e2, int e3, int e4,
			int e5, int e6, int e7, int e8);
		logic [IN_W-1:0] v;
		v = {e8[15:0], e7[15:0], e6[15:0], e5[15:0], e4[15:0],
			e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
		return v;
	endfunction

	function automatic int rand_elem();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) return -16384;
		if (sel == 1) return 16384;
		if (sel == 2) return 0;
		if (sel == 3) return $signed(16'($urandom));
		return $urandom_range(0, 32768) - 16384;
	endfunction

	// Near-rotation: a random signed cyclic permutation with a random perturbation.
	function automatic logic [IN_W-1:0] rand_rotation();
		int e[9];
		int p, s;
		int perm[3][3];
		perm = '{'{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1}};
		p = $urandom_range(0, 2);
		for (int i = 0; i < 9; i++) e[i] = $urandom_range(0, 800) - 400;
		for (int rw = 0; rw < 3; rw++) begin
			s = $urandom_range(0, 1) ? 1 : -1;
			e[rw*3 + perm[p][rw]] = s * (16384 - int'($urandom_range(0, 6000)));
		end
		return pack_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 2) != 0) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(20, 80);
		return $urandom_range(1, 4);
	endfunction

	// Driver: present the head of the pending queue, advance on each accepted transaction.
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_quats.push_back(convert_matrix(s_tdata));
				void'(pending_mats.pop_front());
				send_gap = gap_len();
			end
			if ((!s_tvalid || s_tready) || !s_tvalid) begin
				if (s_tvalid && !s_tready) begin
					// hold the offered transaction
				end else if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_mats.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_mats[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	int recv_gap = 0;
	always @(posedge clk) begin
		quat_t want;
		logic [15:0] got_x, got_y, got_z, got_w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_x = m_tdata[15:0];
				got_y = m_tdata[31:16];
				got_z = m_tdata[47:32];
				got_w = m_tdata[63:48];
				if (expected_quats.size() == 0) begin
					$display("%0t: unexpected result qx=%h qy=%h qz=%h qw=%h user=%h",
						$time, got_x, got_y, got_z, got_w, m_tuser);
					errors++;
				end else begin
					want = expected_quats.pop_front();
					if (got_x !== want.qx || got_y !== want.qy || got_z !== want.qz ||
							got_w !== want.qw || m_tuser[1:0] !== want.branch ||
							m_tuser[2] !== want.degen) begin
						$display("%0t: expected q=%h %h %h %h case=%0d degen=%b, got %h %h %h %h case=%0d degen=%b",
							$time, want.qx, want.qy, want.qz, want.qw, want.branch, want.degen,
							got_x, got_y, got_z, got_w, m_tuser[1:0], m_tuser[2]);
						errors++;
					end
				end
				recv_gap = gap_len();
			end
			if (hold_receiver) begin
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rotation_matrix_to_quaternion_core: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: identity, half-turns, extremes and out-of-range cases.
		pending_mats.push_back(pack_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
		pending_mats.push_back(pack_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
		pending_mats.push_back(pack_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
		pending_mats.push_back(pack_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
		pending_mats.push_back(pack_mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
		pending_mats.push_back(pack_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// x-y tie on the diagonal, taken by the y branch
		pending_mats.push_back(pack_mat(-8192, 0, 0, 0, -8192, 0, 0, 0, -16384));
		// positive trace, taken by the trace branch
		pending_mats.push_back(pack_mat(16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
		pending_mats.push_back(pack_mat(-16384, -16384, -16384, -16384, -16384,
			-16384, -16384, -16384, -16384));
		pending_mats.push_back(pack_mat(16384, 16384, 16384, 16384, -16384,
			16384, 16384, 16384, -16384));
		// ties on the diagonal: x loses on equality, y loses to z on equality
		pending_mats.push_back(pack_mat(-4000, 100, 200, 300, -4000, 400, 500, 600, -4000));
		pending_mats.push_back(pack_mat(-2000, 9, 9, 9, -1000, 9, 9, 9, -1000));
		// trace exactly zero
		pending_mats.push_back(pack_mat(8192, 50, 60, 70, -4096, 80, 90, 10, -4096));
		// out-of-range raw codes, saturating quotients
		pending_mats.push_back(pack_mat(-32768, 32767, -32768, 32767, -32768,
			32767, -32768, 32767, 32767));
		pending_mats.push_back(pack_mat(32767, 32767, -32768, -32768, 32767,
			32767, 32767, -32768, 32767));
		pending_mats.push_back(pack_mat(-16384, 16384, 16384, 16384, -16384,
			-16384, -16384, 16384, -16383));
		pending_mats.push_back(pack_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		pending_mats.push_back(pack_mat(-21846, -16384, 16384, 16384, 10922,
			-16384, -16384, 16384, 10922));
		wait (pending_mats.size() == 0 && expected_quats.size() == 0);

		// Long receiver hold-off while the sender keeps offering.
		hold_receiver = 1;
		for (int i = 0; i < 150; i++) pending_mats.push_back(rand_rotation());
		repeat (400) @(posedge clk);
		hold_receiver = 0;

		for (int i = 0; i < 1400; i++) begin
			if ($urandom_range(0, 3) == 0)
				pending_mats.push_back(pack_mat(rand_elem(), rand_elem(), rand_elem(),
					rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
					rand_elem()));
			else
				pending_mats.push_back(rand_rotation());
			if (i == 700) begin
				// sender pauses until every expected result has come back
				wait (pending_mats.size() == 0 && expected_quats.size() == 0);
			end
		end
		wait (pending_mats.size() == 0 && expected_quats.size() == 0);
		repeat (LATENCY * 2) @(posedge clk);
		if (errors == 0 && expected_quats.size() == 0) begin
			$display("rotation_matrix_to_quaternion_core: match");
		end else begin
			$display("rotation_matrix_to_quaternion_core: mismatch");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/rmq_pkg.sv
hdl/rmq_sqrt_cell.sv
hdl/rmq_div_cell.sv
hdl/rotation_matrix_to_quaternion_core.sv
hdl/rmq_checker.sv
verif/testbench.sv
